### rtl/tsss_pkg.sv
package tsss_pkg;

    localparam int SAMPLE_W = 10;
    localparam int CFG_W    = 16;
    localparam int DIGIT_W  = 4;
    localparam int EN_W     = 3;
    localparam int SEG_W    = 7;

    localparam logic [SAMPLE_W-1:0] MAX_SAMPLE    = 10'd999;
    localparam logic [CFG_W-1:0]    REFRESH_RESET = 16'd100;

    // one-hot digit enables
    localparam logic [EN_W-1:0] EN_TENS   = 3'b100;
    localparam logic [EN_W-1:0] EN_UNITS  = 3'b010;
    localparam logic [EN_W-1:0] EN_TENTHS = 3'b001;

    typedef struct packed {
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] units;
        logic [DIGIT_W-1:0] tenths;
    } digits_t;

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic [EN_W-1:0]  digit_enable;
    } scan_out_t;

endpackage

### rtl/temperature_seven_segment_scanner_top.sv
// Three-digit multiplexed seven-segment driver for a temperature in tenths of a
// degree. Every input request is one refresh tick and yields exactly one output
// request: a one-hot digit enable (tens, units, tenths in turn) and its
// active-high segment pattern. The sample is taken only on resample ticks; after
// the tenths digit the block resamples once refresh_ticks ticks have passed,
// otherwise it rescans. One request is taken per clock cycle while the result
// side is not stalled; a request waits in the input register, and its result,
// through the digit split, is registered in the result register. A stalled
// result holds the input register, and then the input side stalls too.
module temperature_seven_segment_scanner_top
    import tsss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] sample_tenths
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] digit_enable, [9:3] segments
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata       // refresh_ticks
);

    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                out_valid_reg;
    scan_out_t           out_data_reg;
    scan_out_t           result;
    logic                advance;

    // move the held request forward when the result slot is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    tsss_scan_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .sample    (in_sample_reg),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_sample_reg <= s_axis_tdata[SAMPLE_W-1:0];
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

endmodule

### rtl/tsss_digit_split.sv
module tsss_digit_split
    import tsss_pkg::*;
(
    input  logic [SAMPLE_W-1:0] sample,
    output digits_t             digits
);

    logic [SAMPLE_W-1:0] sat;
    logic [15:0]         tens_prod;
    logic [DIGIT_W-1:0]  tens;
    logic [SAMPLE_W-1:0] rem_full;
    logic [6:0]          rem;
    logic [14:0]         units_prod;
    logic [DIGIT_W-1:0]  units;
    logic [6:0]          tenths_full;

    // clamp, then divide by 100 and 10 through reciprocal multiplies (exact for 0..999)
    assign sat         = (sample > MAX_SAMPLE) ? MAX_SAMPLE : sample;
    assign tens_prod   = {6'd0, sat} * 16'd41;
    assign tens        = tens_prod[15:12];
    assign rem_full    = sat - ({6'd0, tens} * 10'd100);
    assign rem         = rem_full[6:0];
    assign units_prod  = {8'd0, rem} * 15'd205;
    assign units       = units_prod[14:11];
    assign tenths_full = rem - ({3'd0, units} * 7'd10);

    assign digits.tens   = tens;
    assign digits.units  = units;
    assign digits.tenths = tenths_full[3:0];

endmodule

### rtl/tsss_scan_core.sv
module tsss_scan_core
    import tsss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    output scan_out_t           result
);

    typedef enum logic [1:0] {
        PH_RESAMPLE = 2'd0,
        PH_TENS     = 2'd1,
        PH_UNITS    = 2'd2,
        PH_TENTHS   = 2'd3
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [CFG_W-1:0] tick_reg, tick_next;
    logic [CFG_W-1:0] tick_eff;
    logic [CFG_W-1:0] refresh_reg;
    digits_t          digits_reg, digits_next;
    digits_t          split_digits;
    logic [DIGIT_W-1:0] shown;

    function automatic logic [SEG_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] g;
        case (d)
            4'd0:    g = 7'h3F;
            4'd1:    g = 7'h06;
            4'd2:    g = 7'h5B;
            4'd3:    g = 7'h4F;
            4'd4:    g = 7'h66;
            4'd5:    g = 7'h6D;
            4'd6:    g = 7'h7D;
            4'd7:    g = 7'h07;
            4'd8:    g = 7'h7F;
            4'd9:    g = 7'h6F;
            default: g = 7'h00;
        endcase
        return g;
    endfunction

    tsss_digit_split u_split (
        .sample (sample),
        .digits (split_digits)
    );

    always_comb
    begin
        digits_next         = digits_reg;
        tick_eff            = tick_reg;
        phase_next          = phase_reg;
        result.digit_enable = EN_TENS;
        shown               = digits_reg.tens;
        case (phase_reg)
            PH_RESAMPLE:
            begin
                // latch the new sample and show its tens digit in the same tick
                digits_next = split_digits;
                tick_eff    = '0;
                shown       = split_digits.tens;
                phase_next  = PH_UNITS;
            end
            PH_TENS:
            begin
                phase_next = PH_UNITS;
            end
            PH_UNITS:
            begin
                result.digit_enable = EN_UNITS;
                shown               = digits_reg.units;
                phase_next          = PH_TENTHS;
            end
            PH_TENTHS:
            begin
                result.digit_enable = EN_TENTHS;
                shown               = digits_reg.tenths;
                phase_next          = (tick_reg >= refresh_reg) ? PH_RESAMPLE : PH_TENS;
            end
            default:
            begin
                phase_next = PH_RESAMPLE;
            end
        endcase
        // hold at full scale instead of wrapping
        tick_next       = (tick_eff == '1) ? tick_eff : tick_eff + 1'b1;
        result.segments = glyph(shown);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_RESAMPLE;
            tick_reg    <= '0;
            digits_reg  <= '0;
            refresh_reg <= REFRESH_RESET;
        end
        else
        begin
            if (step)
            begin
                phase_reg  <= phase_next;
                tick_reg   <= tick_next;
                digits_reg <= digits_next;
            end
            if (cfg_we)
            begin
                refresh_reg <= cfg_wdata;
            end
        end
    end

    a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(result.digit_enable))
        else $error("digit enable not one-hot");

    a_units_to_tenths: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_UNITS |=> phase_reg == PH_TENTHS)
        else $error("units digit not followed by tenths digit");

    a_resample_count: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_RESAMPLE |=> tick_reg == 16'd1 && phase_reg == PH_UNITS)
        else $error("resample did not restart the tick count");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(tick_reg) && $stable(digits_reg))
        else $error("scan state moved without a request");

endmodule

### tb/segment_scan_checker.sv
`timescale 1ns / 100ps

module segment_scan_checker
    import tsss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] sample_tenths
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [2:0] digit_enable, [9:3] segments
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,      // refresh_ticks
    output int          mismatches,
    output int          pending
);

    localparam int REPORT_LIMIT = 10;
    localparam logic [CFG_W-1:0] TICKS_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_RESAMPLE = 2'd0,
        PH_TENS     = 2'd1,
        PH_UNITS    = 2'd2,
        PH_TENTHS   = 2'd3
    } scan_phase_t;

    scan_phase_t        phase;
    logic [CFG_W-1:0]   refresh;
    logic [CFG_W-1:0]   ticks;
    digits_t            shown_digits;

    scan_out_t          expected_scans[$];
    scan_out_t          want;
    scan_out_t          got;

    function automatic logic [SEG_W-1:0] glyph_of(input logic [DIGIT_W-1:0] digit);
        case (digit)
            4'd0:    return 7'h3F;
            4'd1:    return 7'h06;
            4'd2:    return 7'h5B;
            4'd3:    return 7'h4F;
            4'd4:    return 7'h66;
            4'd5:    return 7'h6D;
            4'd6:    return 7'h7D;
            4'd7:    return 7'h07;
            4'd8:    return 7'h7F;
            4'd9:    return 7'h6F;
            default: return 7'h00;
        endcase
    endfunction

    // Advance the scan by one refresh tick and return the digit it lights.
    function automatic scan_out_t predict_scan(input logic [SAMPLE_W-1:0] raw);
        scan_out_t          r;
        logic [SAMPLE_W-1:0] s;
        logic [DIGIT_W-1:0] digit;
        if (phase == PH_RESAMPLE)
        begin
            s = (raw > MAX_SAMPLE) ? MAX_SAMPLE : raw;
            shown_digits.tens   = DIGIT_W'(s / 10'd100);
            shown_digits.units  = DIGIT_W'((s / 10'd10) % 10'd10);
            shown_digits.tenths = DIGIT_W'(s % 10'd10);
            ticks = '0;
        end
        case (phase)
            PH_RESAMPLE, PH_TENS:
            begin
                r.digit_enable = EN_TENS;
                digit = shown_digits.tens;
                phase = PH_UNITS;
            end
            PH_UNITS:
            begin
                r.digit_enable = EN_UNITS;
                digit = shown_digits.units;
                phase = PH_TENTHS;
            end
            default:
            begin
                r.digit_enable = EN_TENTHS;
                digit = shown_digits.tenths;
                phase = (ticks >= refresh) ? PH_RESAMPLE : PH_TENS;
            end
        endcase
        // saturate, never wrap
        if (ticks != TICKS_MAX)
            ticks = ticks + 1'b1;
        r.segments = glyph_of(digit);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input scan_out_t w, input logic [15:0] raw);
        if (mismatches < REPORT_LIMIT)
            $display("[%0t] %s: expected enable=%b segments=%h, got tdata=%h",
                     $realtime, what, w.digit_enable, w.segments, raw);
        mismatches = mismatches + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = PH_RESAMPLE;
            refresh = REFRESH_RESET;
            ticks = '0;
            shown_digits = '0;
            expected_scans.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                refresh = cfg_wdata[CFG_W-1:0];

            // compare before pushing so a result cannot match its own request
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[SEG_W+EN_W-1:0];
                if (expected_scans.size() == 0)
                begin
                    note_mismatch("unexpected result", '0, m_axis_tdata);
                end
                else
                begin
                    want = expected_scans.pop_front();
                    if (got.digit_enable !== want.digit_enable ||
                        got.segments !== want.segments ||
                        m_axis_tdata[15:SEG_W+EN_W] !== '0)
                        note_mismatch("result mismatch", want, m_axis_tdata);
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                expected_scans.push_back(predict_scan(s_axis_tdata[SAMPLE_W-1:0]));

            pending = expected_scans.size();
        end
    end

endmodule

### tb/temperature_seven_segment_scanner_top_test.sv
`timescale 1ns / 100ps

module temperature_seven_segment_scanner_top_test;
    import tsss_pkg::*;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata   = '0;   // [9:0] sample_tenths
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [15:0] m_axis_tdata;          // [2:0] digit_enable, [9:3] segments
    logic        cfg_we         = 1'b0;
    logic [15:0] cfg_wdata      = '0;   // refresh_ticks

    int          mismatches;
    int          pending;
    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;

    logic [SAMPLE_W-1:0] tick_samples[$];

    temperature_seven_segment_scanner_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    segment_scan_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return MAX_SAMPLE;
            1:       return '0;
            2:       return SAMPLE_W'($urandom_range(1000, 1023));
            default: return SAMPLE_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // Present queued samples one request at a time until the last is taken.
    task automatic drive_ticks();
        bit presenting;
        presenting = 1'b0;
        while (tick_samples.size() != 0 || presenting)
        begin
            @(posedge clk);
            if (presenting && s_axis_tready)
                presenting = 1'b0;
            if (!presenting)
            begin
                if (tick_samples.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'b0, tick_samples.pop_front()};
                    presenting = 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_refresh(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin sender_idle_pct = 61; receiver_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 61; end
            IDLE_BOTH:     begin sender_idle_pct = 12; receiver_stall_pct = 12; end
            default:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        endcase
    endtask

    task automatic run_random(input logic [CFG_W-1:0] refresh, input int count,
                              input idle_mode_t mode);
        write_refresh(refresh);
        set_idling(mode);
        repeat (count)
            tick_samples.push_back(random_sample());
        drive_ticks();
    endtask

    initial
    begin
        logic [SAMPLE_W-1:0] directed[8];

        directed = '{10'd512, 10'd1023, 10'd1000, 10'd0,
                     10'd123, 10'd456, 10'd789, 10'd345};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // one scan at the reset period before any write
        repeat (3)
            tick_samples.push_back(MAX_SAMPLE);
        drive_ticks();

        // zero period: resample after every scan; repeat each sample so the
        // resample tick always lands on it whatever the phase
        write_refresh('0);
        foreach (directed[i])
            repeat (3)
                tick_samples.push_back(directed[i]);
        drive_ticks();

        run_random(16'd1,    110, IDLE_SENDER);
        run_random(16'd100,  110, IDLE_RECEIVER);
        run_random(16'd2,    110, IDLE_BOTH);
        run_random(16'd0,    100, IDLE_NONE);
        // full period: keep rescanning the same digits
        run_random(16'hFFFF, 110, IDLE_NONE);
        run_random(CFG_W'($urandom_range(3, 50)), 110, IDLE_SENDER);
        run_random(16'd5,    110, IDLE_RECEIVER);
        run_random(16'd1000, 60,  IDLE_BOTH);
        run_random(16'd1,    100, IDLE_BOTH);

        set_idling(IDLE_NONE);
        wait_idle();
        repeat (8) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### temperature_seven_segment_scanner_top.f
rtl/tsss_pkg.sv
rtl/tsss_digit_split.sv
rtl/tsss_scan_core.sv
rtl/temperature_seven_segment_scanner_top.sv
tb/segment_scan_checker.sv
tb/temperature_seven_segment_scanner_top_test.sv
